/* rtl/ultrasonic_single_pin_ranger_assert.svh */
// Assertion macros for the ultrasonic ranger block.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef ULTRASONIC_SINGLE_PIN_RANGER_ASSERT_SVH
`define ULTRASONIC_SINGLE_PIN_RANGER_ASSERT_SVH

// Same-cycle implication, gated off while in reset.
`define USPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off while in reset.
`define USPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/uspr_pkg.sv */
// Types and constants for the ultrasonic single-pin ranger.
// No dependencies; used by ultrasonic_single_pin_ranger.
package uspr_pkg;

	typedef struct packed {
		logic echo_level;
		logic start_request;
	} tick_t;

	typedef struct packed {
		logic       pin_drive;
		logic       pin_driving;
		logic [9:0] distance_cm;
		logic       measure_done;
		logic       timed_out;
		logic       busy_res;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE_DRIVEN   = 3'd0,
		PH_IDLE_RELEASED = 3'd1,
		PH_LOW           = 3'd2,
		PH_PULSE         = 3'd3,
		PH_WAIT_PREV_END = 3'd4,
		PH_WAIT_START    = 3'd5,
		PH_WAIT_END      = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		REG_LOW_TIME   = 2'd0,
		REG_PULSE_TIME = 2'd1,
		REG_TIMEOUT    = 2'd2,
		REG_FAULT_DIST = 2'd3
	} reg_idx_t;

	localparam logic [7:0]  LOW_TIME_RST   = 8'd2;
	localparam logic [7:0]  PULSE_TIME_RST = 8'd5;
	localparam logic [15:0] TIMEOUT_RST    = 16'd20000;
	localparam logic [9:0]  FAULT_DIST_RST = 10'd600;
	localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
	localparam logic [9:0]  DIST_MAX       = 10'd1023;

	// Round trip at 29 us/cm: divide by 58 via reciprocal, ceil(2^22/58).
	// Error term 24*65535 stays below 2^22, so the quotient is exact.
	localparam int          RECIP_SHIFT = 22;
	localparam logic [16:0] RECIP_58    = 17'd72316;

endpackage

/* rtl/ultrasonic_single_pin_ranger.sv */
// Ultrasonic single-pin ranger controller, top level.
// Depends on uspr_pkg and ultrasonic_single_pin_ranger_assert.svh.
//
//   channel  | dir | handshake              | beat
//   ---------+-----+------------------------+------------------------------
//   tick     | in  | tick_valid/tick_stall  | uspr_pkg::tick_t, one per us
//   res      | out | res_valid/res_stall    | uspr_pkg::result_t, one per tick
//   cfg      | in  | cfg_we                 | cfg_index selects, cfg_data value
//
// One beat per cycle sustained while res_stall stays low; a tick lands in the s1
// register, then the phase update and the divide-by-58 multiply run from s1 into
// the result register, which raises res_valid.
// Reset puts the phase in idle (pin driven low), zeroes the timer, sets the
// distance to 600 and loads the register defaults.
// tick_stall rises only when s1 holds a beat and the result register is
// full and stalled; otherwise a tick is taken every cycle.
module ultrasonic_single_pin_ranger (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  uspr_pkg::tick_t       tick,
	output logic                  res_valid,
	input  logic                  res_stall,
	output uspr_pkg::result_t     res,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

`include "ultrasonic_single_pin_ranger_assert.svh"

	// config registers
	logic [7:0]  low_time_q;
	logic [7:0]  pulse_time_q;
	logic [15:0] timeout_q;
	logic [9:0]  fault_dist_q;

	// controller state
	uspr_pkg::phase_t phase_q;
	logic [15:0]      elapsed_q;
	logic [9:0]       last_dist_q;

	// input stage
	logic            valid_s1;
	uspr_pkg::tick_t tick_s1;

	// next-state values
	uspr_pkg::phase_t phase_d;
	logic [15:0]      elapsed_d;
	logic [9:0]       dist_d;
	logic             done_d;
	logic             tmo_d;
	logic             ended;
	logic [15:0]      elapsed_inc;
	logic [32:0]      prod;
	logic [10:0]      quot;
	logic [9:0]       echo_dist;

	uspr_pkg::result_t res_d;
	logic              fire;
	logic              res_free;

	assign res_free   = !res_valid || !res_stall;
	assign fire       = valid_s1 && res_free;
	assign tick_stall = valid_s1 && !res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_time_q   <= uspr_pkg::LOW_TIME_RST;
			pulse_time_q <= uspr_pkg::PULSE_TIME_RST;
			timeout_q    <= uspr_pkg::TIMEOUT_RST;
			fault_dist_q <= uspr_pkg::FAULT_DIST_RST;
		end else if (cfg_we) begin
			case (uspr_pkg::reg_idx_t'(cfg_index))
				uspr_pkg::REG_LOW_TIME:   low_time_q   <= cfg_data[7:0];
				uspr_pkg::REG_PULSE_TIME: pulse_time_q <= cfg_data[7:0];
				uspr_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data;
				uspr_pkg::REG_FAULT_DIST: fault_dist_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// s1: capture the tick; empties when its beat moves into the result reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	// saturating timer and echo-time to centimeters
	assign elapsed_inc = (elapsed_q == uspr_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign prod        = 33'(elapsed_inc) * 33'(uspr_pkg::RECIP_58);
	assign quot        = prod[32:uspr_pkg::RECIP_SHIFT];
	assign echo_dist   = quot[10] ? uspr_pkg::DIST_MAX : quot[9:0];

	// next state
	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_q;
		dist_d    = last_dist_q;
		done_d    = 1'b0;
		tmo_d     = 1'b0;
		ended     = 1'b0;
		case (phase_q)
			uspr_pkg::PH_IDLE_DRIVEN, uspr_pkg::PH_IDLE_RELEASED: begin
				if (tick_s1.start_request) begin
					phase_d   = uspr_pkg::PH_LOW;
					elapsed_d = 16'd0;
				end
			end
			uspr_pkg::PH_LOW: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= 16'(low_time_q)) begin
					phase_d   = uspr_pkg::PH_PULSE;
					elapsed_d = 16'd0;
					ended     = 1'b1;
				end
			end
			uspr_pkg::PH_PULSE: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc >= 16'(pulse_time_q)) begin
					phase_d   = uspr_pkg::PH_WAIT_PREV_END;
					elapsed_d = 16'd0;
					ended     = 1'b1;
				end
			end
			uspr_pkg::PH_WAIT_PREV_END: begin
				elapsed_d = elapsed_inc;
				if (!tick_s1.echo_level) begin
					phase_d   = uspr_pkg::PH_WAIT_START;
					elapsed_d = 16'd0;
					ended     = 1'b1;
				end
			end
			uspr_pkg::PH_WAIT_START: begin
				elapsed_d = elapsed_inc;
				if (tick_s1.echo_level) begin
					phase_d   = uspr_pkg::PH_WAIT_END;
					elapsed_d = 16'd0;
					ended     = 1'b1;
				end
			end
			uspr_pkg::PH_WAIT_END: begin
				elapsed_d = elapsed_inc;
				if (!tick_s1.echo_level) begin
					phase_d   = uspr_pkg::PH_IDLE_RELEASED;
					elapsed_d = 16'd0;
					dist_d    = echo_dist;
					done_d    = 1'b1;
					ended     = 1'b1;
				end
			end
			default: begin
				phase_d   = uspr_pkg::PH_IDLE_DRIVEN;
				elapsed_d = 16'd0;
				ended     = 1'b1;
			end
		endcase
		// abort check applies to busy phases only
		if (phase_q != uspr_pkg::PH_IDLE_DRIVEN && phase_q != uspr_pkg::PH_IDLE_RELEASED &&
		    !ended && elapsed_inc >= timeout_q) begin
			phase_d   = uspr_pkg::PH_IDLE_DRIVEN;
			elapsed_d = 16'd0;
			dist_d    = fault_dist_q;
			done_d    = 1'b1;
			tmo_d     = 1'b1;
		end
	end

	// outputs, from the phase after this tick
	always_comb begin
		res_d              = '0;
		res_d.distance_cm  = dist_d;
		res_d.measure_done = done_d;
		res_d.timed_out    = tmo_d;
		res_d.busy_res     = 1'b1;
		case (phase_d)
			uspr_pkg::PH_IDLE_DRIVEN: begin
				res_d.pin_driving = 1'b1;
				res_d.busy_res    = 1'b0;
			end
			uspr_pkg::PH_IDLE_RELEASED: begin
				res_d.busy_res = 1'b0;
			end
			uspr_pkg::PH_LOW: begin
				res_d.pin_driving = 1'b1;
			end
			uspr_pkg::PH_PULSE: begin
				res_d.pin_driving = 1'b1;
				res_d.pin_drive   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uspr_pkg::PH_IDLE_DRIVEN;
			elapsed_q   <= 16'd0;
			last_dist_q <= uspr_pkg::FAULT_DIST_RST;
			res_valid   <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= phase_d;
				elapsed_q   <= elapsed_d;
				last_dist_q <= dist_d;
			end
			if (res_free) begin
				res_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res <= res_d;
		end
	end

	// checks
	`USPR_ASSERT_IMP(a_tmo_shape, res_valid && res.timed_out,
		res.measure_done && res.pin_driving && !res.pin_drive && !res.busy_res,
		"timeout beat must finish with pin driven low")
	`USPR_ASSERT_NXT(a_fire_lands, fire, res_valid,
		"processed tick did not reach the result register")
	`USPR_ASSERT_IMP(a_released_low, res_valid && !res.pin_driving, !res.pin_drive,
		"pin drive high while released")
	`USPR_ASSERT_IMP(a_stall_full, tick_stall, valid_s1 && res_valid && res_stall,
		"tick stalled with room downstream")

endmodule
